// ===== hw/rtl/ctb_pkg.sv =====
// Shared types and op codes for the contingency table builder.
`timescale 1ns / 1ps

package ctb_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } ctb_op_e;

  // Commands from the front end to the tracker registers.
  typedef struct packed {
    logic add;
    logic clear;
  } ctb_trk_cmd_t;

endpackage

// ===== hw/rtl/ctb_intf.sv =====
// Valid/ready channel interfaces for requests and read responses.
`timescale 1ns / 1ps

interface ctb_req_if #(
  parameter int LABEL_BITS = 6
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [LABEL_BITS-1:0] label_a;
  logic [LABEL_BITS-1:0] label_b;

  modport source (output valid, output op, output label_a, output label_b, input ready);
  modport sink   (input valid, input op, input label_a, input label_b, output ready);
endinterface

interface ctb_rsp_if #(
  parameter int LABEL_BITS = 6,
  parameter int COUNT_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] cell_count;
  logic [LABEL_BITS-1:0] max_label_a;
  logic [LABEL_BITS-1:0] max_label_b;
  logic [COUNT_BITS-1:0] pairs_total;
  logic                  any_seen;

  modport source (output valid, output cell_count, output max_label_a, output max_label_b,
                  output pairs_total, output any_seen, input ready);
  modport sink   (input valid, input cell_count, input max_label_a, input max_label_b,
                  input pairs_total, input any_seen, output ready);
endinterface

// ===== hw/rtl/ctb_count_mem.sv =====
// Count store: one write port, one registered read port.
`timescale 1ns / 1ps

module ctb_count_mem #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  localparam int Depth = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem_q [Depth];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read-before-write on a same-address collision.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ctb_clear_seq.sv =====
// Clear sequencer: walks the count store writing zeros, after reset and on request.
`timescale 1ns / 1ps

module ctb_clear_seq #(
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic [ADDR_BITS-1:0] addr_o
);

  logic                 busy_d, busy_q;
  logic [ADDR_BITS-1:0] ptr_d, ptr_q;

  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    if (start_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end else if (busy_q) begin
      ptr_d = ptr_q + 1'b1;
      if (ptr_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  // Reset starts a pass so the store comes up zeroed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = ptr_q;

endmodule

// ===== hw/rtl/ctb_tracker.sv =====
// Label maxima, saturating pair counter and seen flag.
`timescale 1ns / 1ps

module ctb_tracker #(
  parameter int LABEL_BITS = 6,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctb_pkg::ctb_trk_cmd_t       cmd_i,
  input  logic       [LABEL_BITS-1:0] label_a_i,
  input  logic       [LABEL_BITS-1:0] label_b_i,
  output logic       [LABEL_BITS-1:0] max_a_o,
  output logic       [LABEL_BITS-1:0] max_b_o,
  output logic       [COUNT_BITS-1:0] pairs_o,
  output logic                        seen_o
);
  import ctb_pkg::*;

  logic [LABEL_BITS-1:0] max_a_d, max_a_q;
  logic [LABEL_BITS-1:0] max_b_d, max_b_q;
  logic [COUNT_BITS-1:0] pairs_d, pairs_q;
  logic                  seen_d, seen_q;

  always_comb begin
    max_a_d = max_a_q;
    max_b_d = max_b_q;
    pairs_d = pairs_q;
    seen_d  = seen_q;
    priority if (cmd_i.clear) begin
      max_a_d = '0;
      max_b_d = '0;
      pairs_d = '0;
      seen_d  = 1'b0;
    end else if (cmd_i.add) begin
      if (label_a_i > max_a_q) max_a_d = label_a_i;
      if (label_b_i > max_b_q) max_b_d = label_b_i;
      if (pairs_q != '1)       pairs_d = pairs_q + 1'b1;
      seen_d = 1'b1;
    end else begin
      seen_d = seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_a_q <= '0;
      max_b_q <= '0;
      pairs_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      max_a_q <= max_a_d;
      max_b_q <= max_b_d;
      pairs_q <= pairs_d;
      seen_q  <= seen_d;
    end
  end

  assign max_a_o = max_a_q;
  assign max_b_o = max_b_q;
  assign pairs_o = pairs_q;
  assign seen_o  = seen_q;

endmodule

// ===== hw/rtl/contingency_table_builder.sv =====
// Top level: contingency table builder with a count store and read-modify-write pipeline.
//
//   channel  dir  payload                                               role
//   req_i    in   op, label_a, label_b                                  add / read / clear
//   rsp_o    out  cell_count, max_label_a, max_label_b, pairs_total,    one per read
//                 any_seen
//
// Adds and reads go back to back, one per cycle unless a read stalls; the store read is
// registered and an add writes back from stage 1, with forwarding from the last write.
// A clear, and reset, run a pass over all 2^(2*LABEL_BITS) cells (4096 by default),
// one cell per cycle through the single write port; req_i.ready is low meanwhile.
// A read whose response cannot enter the output register holds the pipeline and
// drops req_i.ready until rsp_o is taken.
`timescale 1ns / 1ps

module contingency_table_builder #(
  parameter int LABEL_BITS = 6,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctb_req_if.sink   req_i,
  ctb_rsp_if.source rsp_o
);
  import ctb_pkg::*;

  localparam int AddrBits = 2 * LABEL_BITS;

  logic                  req_acc;
  logic                  is_add, is_read, is_clear;
  logic                  s1_adv;
  logic                  clr_busy;
  logic [AddrBits-1:0]   clr_addr;
  ctb_trk_cmd_t          trk_cmd;
  logic [LABEL_BITS-1:0] trk_max_a, trk_max_b;
  logic [COUNT_BITS-1:0] trk_pairs;
  logic                  trk_seen;

  logic                  mem_we;
  logic [AddrBits-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;

  // Stage 1: store data arrives.
  logic                  s1_vld_d, s1_vld_q;
  logic                  s1_rd_q;
  logic [AddrBits-1:0]   s1_addr_q;
  logic [LABEL_BITS-1:0] s1_max_a_q, s1_max_b_q;
  logic [COUNT_BITS-1:0] s1_pairs_q;
  logic                  s1_seen_q;

  logic                  fwd_vld_d, fwd_vld_q;
  logic [AddrBits-1:0]   fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic [COUNT_BITS-1:0] cur_count, inc_count;
  logic                  wr_add;
  logic                  rsp_load;
  logic                  rsp_vld_d, rsp_vld_q;
  logic [COUNT_BITS-1:0] rsp_count_q, rsp_pairs_q;
  logic [LABEL_BITS-1:0] rsp_max_a_q, rsp_max_b_q;
  logic                  rsp_seen_q;

  assign is_add   = (req_i.op == OP_ADD);
  assign is_read  = (req_i.op == OP_READ);
  assign is_clear = (req_i.op == OP_CLEAR);

  assign s1_adv      = !(s1_vld_q && s1_rd_q && rsp_vld_q && !rsp_o.ready);
  assign req_i.ready = !clr_busy && s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  assign trk_cmd.add   = req_acc && is_add;
  assign trk_cmd.clear = req_acc && is_clear;

  ctb_tracker #(
    .LABEL_BITS(LABEL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk_i,
    .rst_ni,
    .cmd_i     (trk_cmd),
    .label_a_i (req_i.label_a),
    .label_b_i (req_i.label_b),
    .max_a_o   (trk_max_a),
    .max_b_o   (trk_max_b),
    .pairs_o   (trk_pairs),
    .seen_o    (trk_seen)
  );

  ctb_clear_seq #(
    .ADDR_BITS(AddrBits)
  ) u_clear_seq (
    .clk_i,
    .rst_ni,
    .start_i (trk_cmd.clear),
    .busy_o  (clr_busy),
    .addr_o  (clr_addr)
  );

  // Latest write wins over the store's read-before-write data.
  assign cur_count = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : mem_rdata;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
  assign wr_add    = s1_vld_q && !s1_rd_q;

  assign mem_we    = clr_busy || wr_add;
  assign mem_waddr = clr_busy ? clr_addr : s1_addr_q;
  assign mem_wdata = clr_busy ? '0 : inc_count;

  ctb_count_mem #(
    .ADDR_BITS(AddrBits),
    .DATA_BITS(COUNT_BITS)
  ) u_count_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (req_acc),
    .raddr_i ({req_i.label_a, req_i.label_b}),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (s1_adv) begin
      s1_vld_d = req_acc && (is_add || is_read);
    end
  end

  always_comb begin
    priority if (trk_cmd.clear) begin
      fwd_vld_d = 1'b0;
    end else if (wr_add) begin
      fwd_vld_d = 1'b1;
    end else begin
      fwd_vld_d = fwd_vld_q;
    end
  end

  assign rsp_load = s1_vld_q && s1_rd_q && s1_adv;

  always_comb begin
    priority if (rsp_load) begin
      rsp_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end else begin
      rsp_vld_d = rsp_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      fwd_vld_q <= fwd_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_rd_q    <= is_read;
      s1_addr_q  <= {req_i.label_a, req_i.label_b};
      s1_max_a_q <= trk_max_a;
      s1_max_b_q <= trk_max_b;
      s1_pairs_q <= trk_pairs;
      s1_seen_q  <= trk_seen;
    end
    if (wr_add) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= inc_count;
    end
    if (rsp_load) begin
      rsp_count_q <= cur_count;
      rsp_max_a_q <= s1_max_a_q;
      rsp_max_b_q <= s1_max_b_q;
      rsp_pairs_q <= s1_pairs_q;
      rsp_seen_q  <= s1_seen_q;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.cell_count  = rsp_count_q;
  assign rsp_o.max_label_a = rsp_max_a_q;
  assign rsp_o.max_label_b = rsp_max_b_q;
  assign rsp_o.pairs_total = rsp_pairs_q;
  assign rsp_o.any_seen    = rsp_seen_q;

`ifndef SYNTH
  // The clear pass and an add write-back never compete for the write port.
  a_no_wr_conflict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_busy && wr_add))
    else $error("clear pass overlaps add write-back");

  // An accepted clear starts the pass on the next cycle.
  a_clear_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_cmd.clear |=> clr_busy)
    else $error("clear did not start the pass");

  // A read blocked at the output holds stage 1 in place.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_rd_q && rsp_vld_q && !rsp_o.ready)
      |=> (s1_vld_q && s1_rd_q && $stable(s1_addr_q)))
    else $error("stalled read left stage 1");

  // A response is loaded only into a free or draining output register.
  a_rsp_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!rsp_vld_q || rsp_o.ready))
    else $error("response overwritten before transaction");
`endif

endmodule

// ===== tb/contingency_table_builder_test.sv =====
// Self-checking testbench for the contingency table builder against a cell tally.
`timescale 1ns / 1ps

module contingency_table_builder_test;
  import ctb_pkg::*;

  localparam int LABEL_BITS   = 6;
  localparam int COUNT_BITS   = 32;
  localparam int CELLS        = 1 << (2 * LABEL_BITS);
  localparam int PHASE_ITEMS  = 156;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;

  // Op code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    count_t cell_count;
    label_t max_label_a;
    label_t max_label_b;
    count_t pairs_total;
    logic   any_seen;
  } readout_t;

  // Tracks the table and trackers; queues one expected readout per accepted read.
  class cell_tally;
    count_t   cells [CELLS];
    label_t   top_a;
    label_t   top_b;
    count_t   pairs;
    logic     seen;
    readout_t expected_readouts [$];
    int       mismatches;

    function new();
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cells[i]) cells[i] = '0;
      top_a = '0;
      top_b = '0;
      pairs = '0;
      seen  = 1'b0;
    endfunction

    function void apply_request(logic [1:0] op, label_t a, label_t b);
      readout_t r;
      int       addr;
      addr = int'({a, b});
      case (op)
        OP_ADD: begin
          if (cells[addr] != '1) cells[addr] = cells[addr] + 1'b1;
          if (pairs != '1) pairs = pairs + 1'b1;
          if (a > top_a) top_a = a;
          if (b > top_b) top_b = b;
          seen = 1'b1;
        end
        OP_READ: begin
          r.cell_count  = cells[addr];
          r.max_label_a = top_a;
          r.max_label_b = top_b;
          r.pairs_total = pairs;
          r.any_seen    = seen;
          expected_readouts.push_back(r);
        end
        OP_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"ERROR: readout with none pending: ",
                    "count=%0d max_a=%0d max_b=%0d pairs=%0d seen=%0b"},
                   got.cell_count, got.max_label_a, got.max_label_b, got.pairs_total,
                   got.any_seen);
        return;
      end
      want = expected_readouts.pop_front();
      if (got.cell_count !== want.cell_count || got.max_label_a !== want.max_label_a ||
          got.max_label_b !== want.max_label_b || got.pairs_total !== want.pairs_total ||
          got.any_seen !== want.any_seen) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: expected count=%0d max_a=%0d max_b=%0d pairs=%0d seen=%0b",
                   want.cell_count, want.max_label_a, want.max_label_b, want.pairs_total,
                   want.any_seen);
          $display("       actual   count=%0d max_a=%0d max_b=%0d pairs=%0d seen=%0b",
                   got.cell_count, got.max_label_a, got.max_label_b, got.pairs_total,
                   got.any_seen);
        end
      end
    endfunction

    function int failures();
      return mismatches + expected_readouts.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ctb_req_if #(.LABEL_BITS(LABEL_BITS)) req_if ();
  ctb_rsp_if #(.LABEL_BITS(LABEL_BITS), .COUNT_BITS(COUNT_BITS)) rsp_if ();

  contingency_table_builder #(
    .LABEL_BITS(LABEL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  cell_tally   tally;
  int          send_idle_pct = 0;
  int          rsp_stall_pct = 0;
  int unsigned cycles = 0;
  readout_t    captured;
  int          idle_by_phase  [4] = '{0, 45, 0, 18};
  int          stall_by_phase [4] = '{0, 0, 45, 18};

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) begin
    rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      captured.cell_count  = rsp_if.cell_count;
      captured.max_label_a = rsp_if.max_label_a;
      captured.max_label_b = rsp_if.max_label_b;
      captured.pairs_total = rsp_if.pairs_total;
      captured.any_seen    = rsp_if.any_seen;
      tally.check_readout(captured);
    end
  end

  task automatic send_request(logic [1:0] op, label_t a, label_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid   = 1'b1;
    req_if.op      = op;
    req_if.label_a = a;
    req_if.label_b = b;
    do @(posedge clk); while (!req_if.ready);
    tally.apply_request(op, a, b);
  endtask

  task automatic wait_for_readouts();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (tally.expected_readouts.size() != 0) @(posedge clk);
  endtask

  // Mostly adds and reads on a few hot cells so counts build up; clears are rare (long walk).
  task automatic send_random();
    int         pick;
    logic [1:0] op;
    label_t     a;
    label_t     b;
    pick = $urandom_range(199);
    if (pick < 110) op = OP_ADD;
    else if (pick < 188) op = OP_READ;
    else if (pick < 199) op = OP_UNUSED;
    else op = OP_CLEAR;
    if ($urandom_range(9) < 7) begin
      a = label_t'($urandom_range(3));
      b = label_t'($urandom_range(3));
    end else begin
      a = label_t'($urandom_range(63));
      b = label_t'($urandom_range(63));
    end
    send_request(op, a, b);
  endtask

  initial begin
    tally          = new();
    req_if.valid   = 1'b0;
    req_if.op      = OP_ADD;
    req_if.label_a = '0;
    req_if.label_b = '0;
    rsp_if.ready   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reads of an empty table
    send_request(OP_READ, 6'd0, 6'd0);
    send_request(OP_READ, 6'd63, 6'd63);
    // back-to-back adds to one cell, then read right behind them
    send_request(OP_ADD, 6'd1, 6'd2);
    send_request(OP_ADD, 6'd1, 6'd2);
    send_request(OP_READ, 6'd1, 6'd2);
    send_request(OP_READ, 6'd10, 6'd20);
    send_request(OP_ADD, 6'd0, 6'd0);
    send_request(OP_READ, 6'd0, 6'd0);
    send_request(OP_UNUSED, 6'd42, 6'd21);
    send_request(OP_READ, 6'd1, 6'd2);
    send_request(OP_ADD, 6'd63, 6'd63);
    send_request(OP_ADD, 6'd63, 6'd0);
    send_request(OP_ADD, 6'd0, 6'd63);
    send_request(OP_READ, 6'd63, 6'd63);
    send_request(OP_READ, 6'd63, 6'd0);
    send_request(OP_READ, 6'd0, 6'd63);
    send_request(OP_CLEAR, 6'd21, 6'd42);
    send_request(OP_READ, 6'd1, 6'd2);
    send_request(OP_ADD, 6'd3, 6'd3);
    send_request(OP_READ, 6'd3, 6'd3);
    send_request(OP_CLEAR, 6'd0, 6'd0);
    send_request(OP_READ, 6'd0, 6'd0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      rsp_stall_pct = stall_by_phase[phase];
      send_request(OP_CLEAR, label_t'($urandom_range(63)), label_t'($urandom_range(63)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 2 && i == PHASE_ITEMS / 2) wait_for_readouts();
        send_random();
      end
    end

    wait_for_readouts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tally.failures() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_intf.sv
hw/rtl/ctb_count_mem.sv
hw/rtl/ctb_clear_seq.sv
hw/rtl/ctb_tracker.sv
hw/rtl/contingency_table_builder.sv
tb/contingency_table_builder_test.sv
